@@ rtl/wsrl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, direction codes and speed encode/decode helpers for the
// wheel speed ramp limiter. No dependencies.
package wsrl_pkg;

    typedef logic signed [8:0] speed_t;
    typedef logic signed [9:0] speed_ext_t;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [7:0] MIN_RAMP = 8'h10;
    localparam logic [7:0] MAX_MAG  = 8'hFF;

    function automatic speed_t decode_speed(input logic [1:0] dir, input logic [7:0] mag);
        speed_t m;
        speed_t s;
        m = speed_t'({1'b0, mag & MAX_MAG});
        unique case (dir)
            DIR_FWD: s = m;
            DIR_REV: s = -m;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] encode_dir(input speed_t s);
        logic [1:0] d;
        priority if (s > 0)
            d = DIR_FWD;
        else if (s < 0)
            d = DIR_REV;
        else
            d = DIR_STOP;
        return d;
    endfunction

    function automatic logic [7:0] encode_mag(input speed_t s);
        logic [8:0] neg;
        neg = 9'd0 - s;
        return (s < 0) ? neg[7:0] : s[7:0];
    endfunction

endpackage

@@ rtl/wheel_speed_ramp_limiter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the wheel speed ramp limiter: sequencer around one shared
// ramp unit that serves both wheels. Depends on wsrl_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one target request (direction and
//   magnitude per wheel). Output channel out_valid/out_ready carries the step
//   commands; the final command of a run has last_step set.
//   cfg_we/cfg_wdata write ramp_step (values below 16 act as 16); write only
//   while idle.
//   Each step runs the shared ramp unit once per wheel, left then right, then
//   holds the command in the output register until the receiver takes it.
//   A request gives up to 33 results, the last of them with last_step set.
//   in_ready is high only while no run is in progress.
//   When out_ready is low the command holds and the sequencer waits.
//   Reset clears both wheel speeds to zero and ramp_step to 16.
module wheel_speed_ramp_limiter_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] target_left_dir,
    input  logic [7:0] target_left_mag,
    input  logic [1:0] target_right_dir,
    input  logic [7:0] target_right_mag,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] step_left_dir,
    output logic [7:0] step_left_mag,
    output logic [1:0] step_right_dir,
    output logic [7:0] step_right_mag,
    output logic       last_step
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RAMP_L,
        ST_RAMP_R,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         ramp_step_reg, ramp_step_next;
    wsrl_pkg::speed_t   cur_left_reg, cur_left_next;
    wsrl_pkg::speed_t   cur_right_reg, cur_right_next;
    wsrl_pkg::speed_t   tgt_left_reg, tgt_left_next;
    wsrl_pkg::speed_t   tgt_right_reg, tgt_right_next;
    logic               left_ok_reg, left_ok_next;
    logic               last_reg, last_next;

    // shared ramp unit
    logic                 sel_right;
    wsrl_pkg::speed_t     ru_cur;
    wsrl_pkg::speed_t     ru_tgt;
    wsrl_pkg::speed_ext_t ru_cur_x;
    wsrl_pkg::speed_ext_t ru_tgt_x;
    wsrl_pkg::speed_ext_t ru_step_x;
    wsrl_pkg::speed_ext_t ru_up;
    wsrl_pkg::speed_ext_t ru_dn;
    logic [7:0]           eff_step;
    wsrl_pkg::speed_t     ru_out;
    logic                 ru_ok;

    assign sel_right = (state_reg == ST_RAMP_R);
    assign ru_cur    = sel_right ? cur_right_reg : cur_left_reg;
    assign ru_tgt    = sel_right ? tgt_right_reg : tgt_left_reg;
    assign eff_step  = (ramp_step_reg < wsrl_pkg::MIN_RAMP) ? wsrl_pkg::MIN_RAMP
                                                            : ramp_step_reg;
    assign ru_cur_x  = wsrl_pkg::speed_ext_t'(ru_cur);
    assign ru_tgt_x  = wsrl_pkg::speed_ext_t'(ru_tgt);
    assign ru_step_x = wsrl_pkg::speed_ext_t'({2'b00, eff_step});
    assign ru_up     = ru_cur_x + ru_step_x;
    assign ru_dn     = ru_cur_x - ru_step_x;

    always_comb
    begin
        ru_ok  = 1'b0;
        ru_out = ru_cur;
        priority if (ru_tgt > ru_cur)
            ru_out = (ru_tgt_x > ru_up) ? ru_up[8:0] : ru_tgt;
        else if (ru_tgt < ru_cur)
            ru_out = (ru_tgt_x < ru_dn) ? ru_dn[8:0] : ru_tgt;
        else
            ru_ok = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        ramp_step_next = ramp_step_reg;
        cur_left_next  = cur_left_reg;
        cur_right_next = cur_right_reg;
        tgt_left_next  = tgt_left_reg;
        tgt_right_next = tgt_right_reg;
        left_ok_next   = left_ok_reg;
        last_next      = last_reg;
        if (cfg_we)
            ramp_step_next = cfg_wdata;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tgt_left_next  = wsrl_pkg::decode_speed(target_left_dir, target_left_mag);
                    tgt_right_next = wsrl_pkg::decode_speed(target_right_dir, target_right_mag);
                    state_next     = ST_RAMP_L;
                end
            end
            ST_RAMP_L:
            begin
                cur_left_next = ru_out;
                left_ok_next  = ru_ok;
                state_next    = ST_RAMP_R;
            end
            ST_RAMP_R:
            begin
                cur_right_next = ru_out;
                last_next      = left_ok_reg & ru_ok;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                    state_next = last_reg ? ST_IDLE : ST_RAMP_L;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ramp_step_reg <= wsrl_pkg::MIN_RAMP;
            cur_left_reg  <= '0;
            cur_right_reg <= '0;
            left_ok_reg   <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ramp_step_reg <= ramp_step_next;
            cur_left_reg  <= cur_left_next;
            cur_right_reg <= cur_right_next;
            left_ok_reg   <= left_ok_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_left_reg  <= tgt_left_next;
        tgt_right_reg <= tgt_right_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = (state_reg == ST_EMIT);
    assign step_left_dir  = wsrl_pkg::encode_dir(cur_left_reg);
    assign step_left_mag  = wsrl_pkg::encode_mag(cur_left_reg);
    assign step_right_dir = wsrl_pkg::encode_dir(cur_right_reg);
    assign step_right_mag = wsrl_pkg::encode_mag(cur_right_reg);
    assign last_step      = last_reg;

`ifndef SYNTHESIS
    // no new request while a command is pending
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid both high");

    // stalled command keeps speeds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cur_left_reg)
            && $stable(cur_right_reg) && $stable(last_reg))
        else $error("stalled command changed");

    // last command means both targets reached
    a_last_met: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_reg |-> cur_left_reg == tgt_left_reg
            && cur_right_reg == tgt_right_reg)
        else $error("last step before targets met");

    // speed stays within magnitude range
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_left_reg != -9'sd256 && cur_right_reg != -9'sd256)
        else $error("wheel speed out of range");

    // run ends after the last command is taken
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_reg |=> in_ready)
        else $error("sequencer did not return to idle");
`endif

endmodule
